// ----- rtl/sblt_pkg.sv -----
// Shared constants, codes and widths for the sequence bitmap link tally.
package sblt_pkg;

  // Largest burst the seen bitmap can track.
  localparam int MAX_PACKETS = 2048;

  // The bitmap is stored as rows of bits in a RAM, one valid flop per row.
  localparam int SEQ_W  = $clog2(MAX_PACKETS);
  localparam int ROW_W  = (MAX_PACKETS < 32) ? MAX_PACKETS : 32;
  localparam int BIT_W  = $clog2(ROW_W);
  localparam int ROWS   = MAX_PACKETS / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Stream and register port widths.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 112;
  localparam int ADDR_W     = 5;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_PACKET = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  localparam logic [1:0] CLS_NONE      = 2'd0;
  localparam logic [1:0] CLS_NEW       = 2'd1;
  localparam logic [1:0] CLS_DUPLICATE = 2'd2;
  localparam logic [1:0] CLS_REORDER   = 2'd3;

  localparam logic [2:0] REG_RUN_ID       = 3'd0;
  localparam logic [2:0] REG_PACKET_COUNT = 3'd1;
  localparam logic [2:0] REG_FRAME_MARKER = 3'd2;
  localparam logic [2:0] REG_SILENCE      = 3'd3;
  localparam logic [2:0] REG_HARD_CAP     = 3'd4;
  localparam logic [2:0] REG_GRACE        = 3'd5;
  localparam logic [2:0] REG_POWER_EN     = 3'd6;

endpackage

// ----- rtl/sblt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module sblt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sequence_bitmap_link_tally_top.sv -----
// Top level of the sequence bitmap link tally: burst tally, bitmap and registers.
//
//   Channel  Direction  Group                     Contents
//   -------  ---------  ------------------------  ---------------------------------------
//   s        in         s_tvalid/s_tready         action in tuser, packet and tick fields
//   m        out        m_tvalid/m_tready         class in tuser, counters and flags
//   apb      in         psel/penable/pwrite/...   seven limit and match registers
//
// The cycle that accepts a transfer reads its bitmap row from the RAM; the work stage then
// classifies it, writes the row back and loads the result register. A new transfer can be
// accepted in every cycle while the result register is not stalled, giving one item per
// cycle; the RAM's single read and single write port allow this rate.
// Reset is synchronous and active high; after reset the burst is closed until a start item.
// A stalled result holds in the output register while the next item waits in the work stage.
module sequence_bitmap_link_tally_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Fields from bit 0: packet_marker[7:0], packet_run[23:8], packet_seq[39:24],
  // power_detect[40], zero fill up to bit 47.
  input  logic [sblt_pkg::IN_DATA_W-1:0]   s_tdata,
  // Fields from bit 0: action[1:0].
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Fields from bit 0: unique_count[11:0], duplicate_count[27:12], reorder_count[38:28],
  // power_hit_count[70:39], power_sample_count[102:71], final_seen[103], burst_done[104],
  // zero fill up to bit 111.
  output logic [sblt_pkg::OUT_DATA_W-1:0]  m_tdata,
  // Fields from bit 0: packet_class[1:0].
  output logic [1:0]                       m_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sblt_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  import sblt_pkg::*;

  // Configuration registers.
  logic [15:0] expected_run_id;
  logic [11:0] packet_count;
  logic [7:0]  frame_marker;
  logic [23:0] silence_limit;
  logic [23:0] hard_cap_limit;
  logic [15:0] grace_limit;
  logic        power_sample_enable;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_run_id     <= 16'd0;
      packet_count        <= 12'd1;
      frame_marker        <= 8'd0;
      silence_limit       <= 24'd500;
      hard_cap_limit      <= 24'd1000;
      grace_limit         <= 16'd0;
      power_sample_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RUN_ID:       expected_run_id     <= pwdata[15:0];
        REG_PACKET_COUNT: packet_count        <= pwdata[11:0];
        REG_FRAME_MARKER: frame_marker        <= pwdata[7:0];
        REG_SILENCE:      silence_limit       <= pwdata[23:0];
        REG_HARD_CAP:     hard_cap_limit      <= pwdata[23:0];
        REG_GRACE:        grace_limit         <= pwdata[15:0];
        REG_POWER_EN:     power_sample_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_RUN_ID:       prdata = {16'd0, expected_run_id};
      REG_PACKET_COUNT: prdata = {20'd0, packet_count};
      REG_FRAME_MARKER: prdata = {24'd0, frame_marker};
      REG_SILENCE:      prdata = {8'd0, silence_limit};
      REG_HARD_CAP:     prdata = {8'd0, hard_cap_limit};
      REG_GRACE:        prdata = {16'd0, grace_limit};
      REG_POWER_EN:     prdata = {31'd0, power_sample_enable};
      default:          prdata = 32'd0;
    endcase
  end

  // Input acceptance and the work stage that follows it.
  logic        in_accept;
  logic        s1_valid;
  logic        s1_fire;
  logic [1:0]  s1_action;
  logic [7:0]  s1_marker;
  logic [15:0] s1_run;
  logic [15:0] s1_seq;
  logic        s1_power;

  assign s1_fire   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || s1_fire;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action <= s_tuser;
      s1_marker <= s_tdata[7:0];
      s1_run    <= s_tdata[23:8];
      s1_seq    <= s_tdata[39:24];
      s1_power  <= s_tdata[40];
    end
  end

  // Seen bitmap: rows in RAM, a valid flop per row so that a start clears it at once.
  logic [ROW_AW-1:0] rd_row;
  logic [ROW_AW-1:0] s1_row;
  logic [BIT_W-1:0]  s1_bit;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  row_data;
  logic [ROW_W-1:0]  wr_data;
  logic              row_we;
  logic              ram_we;
  logic              clear_rows;
  logic              row_valid [ROWS];

  // Forwarding for a row written at the same edge that the next item read it.
  logic              fwd_valid;
  logic [ROW_AW-1:0] fwd_row;
  logic [ROW_W-1:0]  fwd_data;

  assign rd_row = ROW_AW'(s_tdata[39:24] >> BIT_W);
  assign s1_row = ROW_AW'(s1_seq >> BIT_W);
  assign s1_bit = BIT_W'(s1_seq);
  assign ram_we = s1_fire && row_we;

  sblt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_seen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_row),
    .wdata (wr_data),
    .re    (in_accept),
    .raddr (rd_row),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd_valid && (fwd_row == s1_row)) begin
      row_data = fwd_data;
    end else if (row_valid[s1_row]) begin
      row_data = ram_rdata;
    end else begin
      row_data = '0;
    end
  end

  assign wr_data = row_data | (ROW_W'(1) << s1_bit);

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (in_accept) begin
      fwd_valid <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_row  <= s1_row;
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        row_valid[i] <= 1'b0;
      end
    end else if (s1_fire) begin
      if (clear_rows) begin
        for (int i = 0; i < ROWS; i++) begin
          row_valid[i] <= 1'b0;
        end
      end else if (row_we) begin
        row_valid[s1_row] <= 1'b1;
      end
    end
  end

  // Burst state.
  logic [SEQ_W-1:0] last_new_seq, last_new_seq_next;
  logic             last_new_valid, last_new_valid_next;
  logic [11:0]      unique_total, unique_total_next;
  logic [15:0]      duplicate_total, duplicate_total_next;
  logic [10:0]      reorder_total, reorder_total_next;
  logic [31:0]      hit_total, hit_total_next;
  logic [31:0]      sample_total, sample_total_next;
  logic [23:0]      since_start_ms, since_start_ms_next;
  logic [23:0]      since_packet_ms, since_packet_ms_next;
  logic [15:0]      since_final_ms, since_final_ms_next;
  logic             final_flag, final_flag_next;
  logic             done_flag, done_flag_next;
  logic [1:0]       cls;

  // A packet counts only with the right marker and run, and a sequence inside the burst.
  logic pkt_match;
  logic pkt_final;
  logic seen;

  assign pkt_match = (s1_marker == frame_marker) && (s1_run == expected_run_id) &&
                     ({1'b0, s1_seq} < 17'(MAX_PACKETS)) &&
                     (s1_seq < {4'd0, packet_count});
  assign pkt_final = (({1'b0, s1_seq} + 17'd1) == {5'd0, packet_count});
  assign seen      = row_data[s1_bit];

  always_comb begin
    last_new_seq_next    = last_new_seq;
    last_new_valid_next  = last_new_valid;
    unique_total_next    = unique_total;
    duplicate_total_next = duplicate_total;
    reorder_total_next   = reorder_total;
    hit_total_next       = hit_total;
    sample_total_next    = sample_total;
    since_start_ms_next  = since_start_ms;
    since_packet_ms_next = since_packet_ms;
    since_final_ms_next  = since_final_ms;
    final_flag_next      = final_flag;
    done_flag_next       = done_flag;
    cls                  = CLS_NONE;
    row_we               = 1'b0;
    clear_rows           = 1'b0;
    case (s1_action)
      ACT_START: begin
        last_new_seq_next    = '0;
        last_new_valid_next  = 1'b0;
        unique_total_next    = '0;
        duplicate_total_next = '0;
        reorder_total_next   = '0;
        hit_total_next       = '0;
        sample_total_next    = '0;
        since_start_ms_next  = '0;
        since_packet_ms_next = '0;
        since_final_ms_next  = '0;
        final_flag_next      = 1'b0;
        clear_rows           = 1'b1;
        // With the timers at zero only a zero limit can close the burst right away.
        done_flag_next = (silence_limit == 24'd0) || (hard_cap_limit == 24'd0);
      end
      ACT_PACKET: begin
        if (!done_flag) begin
          since_packet_ms_next = '0;
          if (pkt_match) begin
            if (seen) begin
              duplicate_total_next = (&duplicate_total) ? duplicate_total
                                                        : duplicate_total + 16'd1;
              cls = CLS_DUPLICATE;
            end else begin
              row_we = 1'b1;
              unique_total_next = (&unique_total) ? unique_total : unique_total + 12'd1;
              cls = CLS_NEW;
              if (last_new_valid && (SEQ_W'(s1_seq) < last_new_seq)) begin
                reorder_total_next = (&reorder_total) ? reorder_total
                                                      : reorder_total + 11'd1;
                cls = CLS_REORDER;
              end
              last_new_seq_next   = SEQ_W'(s1_seq);
              last_new_valid_next = 1'b1;
            end
            if (pkt_final && !final_flag) begin
              final_flag_next     = 1'b1;
              since_final_ms_next = '0;
            end
          end
          done_flag_next = (final_flag_next && (since_final_ms_next >= grace_limit)) ||
                           (since_packet_ms_next >= silence_limit) ||
                           (since_start_ms_next >= hard_cap_limit);
        end
      end
      ACT_TICK: begin
        if (!done_flag) begin
          since_start_ms_next  = (&since_start_ms) ? since_start_ms
                                                   : since_start_ms + 24'd1;
          since_packet_ms_next = (&since_packet_ms) ? since_packet_ms
                                                    : since_packet_ms + 24'd1;
          if (final_flag) begin
            since_final_ms_next = (&since_final_ms) ? since_final_ms
                                                    : since_final_ms + 16'd1;
          end
          if (power_sample_enable) begin
            sample_total_next = (&sample_total) ? sample_total : sample_total + 32'd1;
            if (s1_power) begin
              hit_total_next = (&hit_total) ? hit_total : hit_total + 32'd1;
            end
          end
          done_flag_next = (final_flag_next && (since_final_ms_next >= grace_limit)) ||
                           (since_packet_ms_next >= silence_limit) ||
                           (since_start_ms_next >= hard_cap_limit);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_new_seq    <= '0;
      last_new_valid  <= 1'b0;
      unique_total    <= '0;
      duplicate_total <= '0;
      reorder_total   <= '0;
      hit_total       <= '0;
      sample_total    <= '0;
      since_start_ms  <= '0;
      since_packet_ms <= '0;
      since_final_ms  <= '0;
      final_flag      <= 1'b0;
      done_flag       <= 1'b1;
    end else if (s1_fire) begin
      last_new_seq    <= last_new_seq_next;
      last_new_valid  <= last_new_valid_next;
      unique_total    <= unique_total_next;
      duplicate_total <= duplicate_total_next;
      reorder_total   <= reorder_total_next;
      hit_total       <= hit_total_next;
      sample_total    <= sample_total_next;
      since_start_ms  <= since_start_ms_next;
      since_packet_ms <= since_packet_ms_next;
      since_final_ms  <= since_final_ms_next;
      final_flag      <= final_flag_next;
      done_flag       <= done_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tuser <= cls;
      m_tdata <= {7'd0, done_flag_next, final_flag_next, sample_total_next,
                  hit_total_next, reorder_total_next, duplicate_total_next,
                  unique_total_next};
    end
  end

endmodule
